// File: sv/crfr_pkg.sv
// shared types, codes and sizes for the command frame receiver and responder
`default_nettype none
package crfr_pkg;

  localparam int unsigned PayloadBytes = 10;
  localparam int unsigned FrameStore   = 6;
  localparam logic [3:0]  OdomLen      = 4'd14;
  localparam logic [3:0]  ShortLen     = 4'd8;
  localparam logic [15:0] IdleMax      = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_TELEM = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_SPARE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CSUM   = 3'd1,
    EV_DRIVE  = 3'd2,
    EV_STOP   = 3'd3,
    EV_ANSWER = 3'd4
  } event_t;

  localparam logic [7:0] CmdVel    = 8'h00;
  localparam logic [7:0] CmdOdom   = 8'h01;
  localparam logic [7:0] CmdStatus = 8'h02;
  localparam logic [7:0] CmdStop   = 8'h03;

  typedef enum logic [1:0] {
    PKT_VEL    = 2'd0,
    PKT_ODOM   = 2'd1,
    PKT_STATUS = 2'd2
  } pkt_t;

  localparam logic [1:0] CfgReqHeader   = 2'd0;
  localparam logic [1:0] CfgReplyHeader = 2'd1;
  localparam logic [1:0] CfgLinkTimeout = 2'd2;

  typedef struct packed {
    logic [7:0]  request_header;
    logic [7:0]  reply_header;
    logic [15:0] link_timeout;
  } cfg_t;

  // one job handed from the parser to the serializer
  typedef struct packed {
    logic                              has_pkt;
    pkt_t                              pkt_kind;
    logic [7:0]                        hdr;
    logic [PayloadBytes-1:0][7:0]      payload;
    event_t                            event_res;
    logic signed [15:0]                drive_left;
    logic signed [15:0]                drive_right;
    logic                              link_up;
  } desc_t;

endpackage
`default_nettype wire

// File: sv/crfr_in_if.sv
// input item channel: received bytes, telemetry updates and ticks
`default_nettype none
interface crfr_in_if;
  import crfr_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         rx_byte;
  logic signed [15:0] wheel_speed_left;
  logic signed [15:0] wheel_speed_right;
  logic [31:0]        pos_x_bits;
  logic [31:0]        pos_y_bits;
  logic [15:0]        heading;
  logic [15:0]        battery_level;
  logic signed [15:0] temperature;

  modport source (output valid, kind, rx_byte, wheel_speed_left, wheel_speed_right,
                  pos_x_bits, pos_y_bits, heading, battery_level, temperature,
                  input ready);
  modport sink (input valid, kind, rx_byte, wheel_speed_left, wheel_speed_right,
                pos_x_bits, pos_y_bits, heading, battery_level, temperature,
                output ready);
endinterface
`default_nettype wire

// File: sv/crfr_out_if.sv
// result channel: reply bytes with event and drive status
`default_nettype none
interface crfr_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         tx_byte;
  logic               tx_valid;
  logic               tx_last;
  logic [2:0]         event_res;
  logic signed [15:0] drive_left;
  logic signed [15:0] drive_right;
  logic               link_up;

  modport source (output valid, tx_byte, tx_valid, tx_last, event_res, drive_left,
                  drive_right, link_up, input ready);
  modport sink (input valid, tx_byte, tx_valid, tx_last, event_res, drive_left,
                drive_right, link_up, output ready);
endinterface
`default_nettype wire

// File: sv/crfr_front.sv
// front end: frame hunting, checksum check, state update and job build
`default_nettype none
module crfr_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire crfr_pkg::cfg_t cfg,
  crfr_in_if.sink             item,
  input  wire logic           q_full,
  output logic                q_push,
  output crfr_pkg::desc_t     q_desc
);
  import crfr_pkg::*;

  logic [2:0]               fpos, fpos_next;
  logic [FrameStore-1:0][7:0] fb;
  logic                     fb_we;
  logic [2:0]               fb_addr;
  logic signed [15:0]       tel_left, tel_right, tel_temp;
  logic [31:0]              tel_x, tel_y;
  logic [15:0]              tel_heading, tel_battery;
  logic signed [15:0]       held_left, held_left_next;
  logic signed [15:0]       held_right, held_right_next;
  logic [15:0]              idle, idle_next;
  logic                     accept;
  logic                     tel_we;
  logic [7:0]               sum;
  logic [15:0]              got;
  logic [7:0]               cmd;

  assign item.ready = !q_full;
  assign accept     = item.valid && item.ready;
  assign q_push     = accept;

  always_comb begin
    fpos_next       = fpos;
    fb_we           = 1'b0;
    fb_addr         = fpos - 3'd1;
    tel_we          = 1'b0;
    held_left_next  = held_left;
    held_right_next = held_right;
    idle_next       = idle;
    sum             = cfg.request_header ^ fb[0] ^ fb[1] ^ fb[2] ^ fb[3] ^ fb[4];
    got             = {item.rx_byte, fb[5]};
    cmd             = fb[0];

    q_desc          = '0;
    q_desc.hdr      = cfg.reply_header;
    q_desc.pkt_kind = PKT_VEL;
    q_desc.event_res = EV_NONE;

    case (kind_t'(item.kind))
      KIND_BYTE: begin
        if (fpos == 3'd0) begin
          fpos_next = (item.rx_byte == cfg.request_header) ? 3'd1 : 3'd0;
        end else if (fpos != 3'd7) begin
          fb_we     = 1'b1;
          fpos_next = fpos + 3'd1;
        end else begin
          // last frame byte is the checksum high byte
          fpos_next = 3'd0;
          if (got != {8'h00, sum}) begin
            q_desc.event_res = EV_CSUM;
          end else begin
            idle_next = '0;
            if (cmd == CmdVel || cmd == CmdOdom || cmd == CmdStatus) begin
              q_desc.has_pkt   = 1'b1;
              q_desc.pkt_kind  = pkt_t'(cmd[1:0]);
              q_desc.event_res = EV_ANSWER;
            end else if (cmd == CmdStop) begin
              q_desc.has_pkt   = 1'b1;
              q_desc.pkt_kind  = PKT_VEL;
              q_desc.event_res = EV_STOP;
            end else begin
              held_left_next   = {fb[2], fb[1]};
              held_right_next  = {fb[4], fb[3]};
              q_desc.event_res = EV_DRIVE;
            end
          end
        end
      end
      KIND_TELEM: tel_we = 1'b1;
      KIND_TICK: begin
        if (idle != IdleMax) idle_next = idle + 16'd1;
      end
      default: ;
    endcase

    case (q_desc.pkt_kind)
      PKT_ODOM:   q_desc.payload = {tel_heading, tel_y, tel_x};
      PKT_STATUS: q_desc.payload = {48'h0, tel_temp, tel_battery};
      default:    q_desc.payload = {48'h0, tel_right, tel_left};
    endcase

    q_desc.drive_left  = held_left_next;
    q_desc.drive_right = held_right_next;
    q_desc.link_up     = idle_next < cfg.link_timeout;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fpos        <= '0;
      tel_left    <= '0;
      tel_right   <= '0;
      tel_x       <= '0;
      tel_y       <= '0;
      tel_heading <= '0;
      tel_battery <= '0;
      tel_temp    <= '0;
      held_left   <= '0;
      held_right  <= '0;
      idle        <= IdleMax;
    end else if (accept) begin
      fpos       <= fpos_next;
      held_left  <= held_left_next;
      held_right <= held_right_next;
      idle       <= idle_next;
      if (tel_we) begin
        tel_left    <= item.wheel_speed_left;
        tel_right   <= item.wheel_speed_right;
        tel_x       <= item.pos_x_bits;
        tel_y       <= item.pos_y_bits;
        tel_heading <= item.heading;
        tel_battery <= item.battery_level;
        tel_temp    <= item.temperature;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && fb_we) fb[fb_addr] <= item.rx_byte;
  end

endmodule
`default_nettype wire

// File: sv/crfr_queue.sv
// two-entry job queue between parser and serializer
`default_nettype none
module crfr_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire crfr_pkg::desc_t push_desc,
  output logic                 full,
  input  wire logic            pop,
  output logic                 valid,
  output crfr_pkg::desc_t      head
);
  import crfr_pkg::*;

  desc_t      mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign full    = count == 2'd2;
  assign valid   = count != 2'd0;
  assign head    = mem[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (do_push) wptr <= !wptr;
      if (do_pop) rptr <= !rptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_desc;
  end

endmodule
`default_nettype wire

// File: sv/crfr_back.sv
// back end: serializes one job into result beats with running xor checksum
`default_nettype none
module crfr_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire crfr_pkg::desc_t q_head,
  output logic                 q_pop,
  crfr_out_if.source           result
);
  import crfr_pkg::*;

  logic [3:0] idx;
  logic [3:0] pl_idx;
  logic [7:0] xacc;
  logic [3:0] len;
  logic [7:0] beat_byte;
  logic       beat_last;
  logic       advance;
  logic       emit;

  assign len     = (q_head.pkt_kind == PKT_ODOM) ? OdomLen : ShortLen;
  assign pl_idx  = idx - 4'd2;
  assign advance = !result.valid || result.ready;
  assign emit    = advance && q_valid;
  assign q_pop   = emit && beat_last;

  always_comb begin
    beat_byte = 8'h00;
    beat_last = 1'b1;
    if (q_head.has_pkt) begin
      beat_last = idx == len - 4'd1;
      if (idx == 4'd0)             beat_byte = q_head.hdr;
      else if (idx == 4'd1)        beat_byte = {6'b0, q_head.pkt_kind};
      else if (idx == len - 4'd2)  beat_byte = xacc;
      else if (idx == len - 4'd1)  beat_byte = 8'h00;
      else                         beat_byte = q_head.payload[pl_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      xacc         <= '0;
      result.valid <= 1'b0;
    end else begin
      if (advance) result.valid <= q_valid;
      if (emit) begin
        if (beat_last) begin
          idx  <= '0;
          xacc <= '0;
        end else begin
          idx  <= idx + 4'd1;
          xacc <= xacc ^ beat_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.tx_byte     <= beat_byte;
      result.tx_valid    <= q_head.has_pkt;
      result.tx_last     <= beat_last;
      result.event_res   <= q_head.event_res;
      result.drive_left  <= q_head.drive_left;
      result.drive_right <= q_head.drive_right;
      result.link_up     <= q_head.link_up;
    end
  end

endmodule
`default_nettype wire

// File: sv/command_frame_receiver_responder_core.sv
// top level: config registers, frame parser, job queue and reply serializer
//
//   channel  role    beat contents
//   item     sink    kind, rx_byte, telemetry fields
//   result   source  tx_byte, tx_valid, tx_last, event_res, drive, link_up
//   cfg      write   cfg_we, cfg_index, cfg_wdata
//
// an item is taken whenever the two-entry job queue has room
// an item with no reply gives one result beat from the serializer
// a reply packet is 8 or 14 beats, one byte a cycle from the serializer unless result stalls
// result stalls fill the queue and then drop item ready
// synchronous reset, no clearing pass
`default_nettype none
module command_frame_receiver_responder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  crfr_in_if.sink          item,
  crfr_out_if.source       result
);
  import crfr_pkg::*;

  cfg_t  cfg;
  desc_t push_desc, head;
  logic  push, full, pop, q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.request_header <= 8'd170;
      cfg.reply_header   <= 8'd187;
      cfg.link_timeout   <= 16'd500;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgReqHeader:   cfg.request_header <= cfg_wdata[7:0];
        CfgReplyHeader: cfg.reply_header   <= cfg_wdata[7:0];
        CfgLinkTimeout: cfg.link_timeout   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  crfr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .q_full (full),
    .q_push (push),
    .q_desc (push_desc)
  );

  crfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (head)
  );

  crfr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (head),
    .q_pop   (pop),
    .result  (result)
  );

endmodule
`default_nettype wire
